FILE: rtl/scfw_pkg.sv
// Shared types and constants of the sector cache write-back controller.
`timescale 1ns / 1ps
`default_nettype none

package scfw_pkg;

    localparam int SECTOR_W = 32;
    localparam int SLOT_W   = 6;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // One slot's status and tag as held in the metadata memory.
    typedef struct packed {
        logic                dirty;
        logic [SECTOR_W-1:0] tag;
    } meta_t;

    localparam int META_W = $bits(meta_t);

endpackage

`default_nettype wire

FILE: rtl/scfw_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module scfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/sector_cache_fifo_writeback.sv
// The tag scan reads one occupied slot per cycle and stops at the first hit; a read or write
// miss with all slots full then passes through the eviction state. An undefined operation skips the scan.
// Throughput: one request at a time, the next accepted once the result is loaded into the output
// register; a stalled result holds the next request.
// Reset: asynchronous; slots are tracked by a fill count, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sector_cache_fifo_writeback #(
    parameter int CACHE_SLOTS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [scfw_pkg::OP_W-1:0]      operation,
    input  wire logic [scfw_pkg::SECTOR_W-1:0]  sector_id,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [scfw_pkg::SLOT_W-1:0]    slot,
    output logic                                hit,
    output logic                                fill_needed,
    output logic                                write_back_needed,
    output logic      [scfw_pkg::SECTOR_W-1:0]  write_back_sector,
    output logic                                evicted
);

    import scfw_pkg::*;

    localparam int IW = $clog2(CACHE_SLOTS);
    localparam int CW = $clog2(CACHE_SLOTS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_EVICT = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic                empty_reg, empty_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;

    logic [IW-1:0]       res_slot_reg, res_slot_next;
    logic                res_hit_reg, res_hit_next;
    logic                res_fill_reg, res_fill_next;
    logic                res_wb_reg, res_wb_next;
    logic [SECTOR_W-1:0] res_wbs_reg, res_wbs_next;
    logic                res_evict_reg, res_evict_next;

    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_hit_reg, out_hit_next;
    logic                out_fill_reg, out_fill_next;
    logic                out_wb_reg, out_wb_next;
    logic [SECTOR_W-1:0] out_wbs_reg, out_wbs_next;
    logic                out_evict_reg, out_evict_next;

    logic                meta_we;
    logic [IW-1:0]       meta_waddr;
    meta_t               meta_wdata;
    logic [IW-1:0]       meta_raddr;
    meta_t               meta_rdata;
    logic                link_we;
    logic [IW-1:0]       link_wdata;
    logic [IW-1:0]       link_rdata;

    logic                issuing;
    logic                match;
    logic                claim_en;
    logic [IW-1:0]       claim_pick;
    logic [IW+SLOT_W-1:0] slot_wide;

    scfw_ram #(
        .WIDTH (META_W),
        .DEPTH (CACHE_SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // Each entry holds the slot that was allocated right after it.
    scfw_ram #(
        .WIDTH (IW),
        .DEPTH (CACHE_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (tail_reg),
        .wdata (link_wdata),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    // Slots are taken lowest first and never freed, so the occupied slots are 0 .. used-1.
    assign issuing    = (state_reg == S_SCAN) && (issue_reg < used_reg);
    assign match      = cmp_valid_reg && (meta_rdata.tag == sector_reg);
    assign meta_raddr = issuing ? issue_reg[IW-1:0] : head_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        sector_next    = sector_reg;
        used_next      = used_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        issue_next     = issue_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        res_slot_next  = res_slot_reg;
        res_hit_next   = res_hit_reg;
        res_fill_next  = res_fill_reg;
        res_wb_next    = res_wb_reg;
        res_wbs_next   = res_wbs_reg;
        res_evict_next = res_evict_reg;
        meta_we        = 1'b0;
        meta_waddr     = cmp_idx_reg;
        meta_wdata     = meta_rdata;
        link_we        = 1'b0;
        link_wdata     = '0;
        claim_en       = 1'b0;
        claim_pick     = used_reg[IW-1:0];

        out_valid_next = out_valid_reg && !out_ready;
        out_slot_next  = out_slot_reg;
        out_hit_next   = out_hit_reg;
        out_fill_next  = out_fill_reg;
        out_wb_next    = out_wb_reg;
        out_wbs_next   = out_wbs_reg;
        out_evict_next = out_evict_reg;
        slot_wide      = {{SLOT_W{1'b0}}, res_slot_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = operation;
                    sector_next    = sector_id;
                    issue_next     = '0;
                    cmp_valid_next = 1'b0;
                    res_slot_next  = '0;
                    res_hit_next   = 1'b0;
                    res_fill_next  = 1'b0;
                    res_wb_next    = 1'b0;
                    res_wbs_next   = '0;
                    res_evict_next = 1'b0;
                    if (operation inside {OP_READ, OP_WRITE, OP_FLUSH})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_SCAN:
            begin
                issue_next     = issue_reg + CW'(issuing);
                cmp_valid_next = issuing;
                cmp_idx_next   = issue_reg[IW-1:0];
                if (match)
                begin
                    res_slot_next = cmp_idx_reg;
                    res_hit_next  = 1'b1;
                    if (op_reg == OP_WRITE)
                    begin
                        meta_we          = 1'b1;
                        meta_wdata.dirty = 1'b1;
                    end
                    else if (op_reg == OP_FLUSH && meta_rdata.dirty)
                    begin
                        res_wb_next      = 1'b1;
                        res_wbs_next     = meta_rdata.tag;
                        meta_we          = 1'b1;
                        meta_wdata.dirty = 1'b0;
                    end
                    state_next = S_OUT;
                end
                else if (!issuing)
                begin
                    if (op_reg == OP_FLUSH)
                    begin
                        state_next = S_OUT;
                    end
                    else if (used_reg == CW'(CACHE_SLOTS))
                    begin
                        // The oldest slot is being read at the FIFO head this cycle.
                        state_next = S_EVICT;
                    end
                    else
                    begin
                        claim_en   = 1'b1;
                        claim_pick = used_reg[IW-1:0];
                        used_next  = used_reg + CW'(1);
                        state_next = S_OUT;
                    end
                end
            end

            S_EVICT:
            begin
                res_evict_next = 1'b1;
                res_wb_next    = meta_rdata.dirty;
                res_wbs_next   = meta_rdata.dirty ? meta_rdata.tag : '0;
                head_next      = link_rdata;
                claim_en       = 1'b1;
                claim_pick     = head_reg;
                state_next     = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = slot_wide[SLOT_W-1:0];
                    out_hit_next   = res_hit_reg;
                    out_fill_next  = res_fill_reg;
                    out_wb_next    = res_wb_reg;
                    out_wbs_next   = res_wbs_reg;
                    out_evict_next = res_evict_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Allocation: write the new tag and append the slot to the FIFO order.
        if (claim_en)
        begin
            meta_we          = 1'b1;
            meta_waddr       = claim_pick;
            meta_wdata.dirty = (op_reg == OP_WRITE);
            meta_wdata.tag   = sector_reg;
            res_slot_next    = claim_pick;
            res_fill_next    = (op_reg == OP_READ);
            tail_next        = claim_pick;
            if (empty_reg)
            begin
                head_next  = claim_pick;
                empty_next = 1'b0;
            end
            else
            begin
                link_we    = 1'b1;
                link_wdata = claim_pick;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sector_reg    <= sector_next;
        cmp_idx_reg   <= cmp_idx_next;
        res_slot_reg  <= res_slot_next;
        res_hit_reg   <= res_hit_next;
        res_fill_reg  <= res_fill_next;
        res_wb_reg    <= res_wb_next;
        res_wbs_reg   <= res_wbs_next;
        res_evict_reg <= res_evict_next;
        out_slot_reg  <= out_slot_next;
        out_hit_reg   <= out_hit_next;
        out_fill_reg  <= out_fill_next;
        out_wb_reg    <= out_wb_next;
        out_wbs_reg   <= out_wbs_next;
        out_evict_reg <= out_evict_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign slot              = out_slot_reg;
    assign hit               = out_hit_reg;
    assign fill_needed       = out_fill_reg;
    assign write_back_needed = out_wb_reg;
    assign write_back_sector = out_wbs_reg;
    assign evicted           = out_evict_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(CACHE_SLOTS))
        else $error("fill count exceeds the number of slots");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (used_reg == '0))
        else $error("FIFO empty while slots are occupied");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVICT) |-> (used_reg == CW'(CACHE_SLOTS)) && !empty_reg)
        else $error("eviction started with a free slot");

    a_hit_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hit_reg) |-> !out_fill_reg && !out_evict_reg)
        else $error("hit reported together with a fill or an eviction");

    a_wb_sector: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_wb_reg) |-> (out_wbs_reg == '0))
        else $error("write-back sector set without a write-back");

endmodule

`default_nettype wire
